// ----- hdl/fqs_pkg.sv -----
`default_nettype none

package fqs_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_fix;
        logic scan;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic is_empty;
        logic scan_done;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/fqs_ctrl.sv -----
`default_nettype none

module fqs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output fqs_pkg::t_dp_cmd o_cmd,
    input  fqs_pkg::t_dp_stat i_stat
);
    import fqs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.op == OP_POP && !i_stat.is_empty) begin
                    n_state = S_POP_WAIT;
                end else if (i_stat.op == OP_SEARCH) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_POP_WAIT: begin
                n_state = S_FINISH;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_POP_WAIT: begin
                o_cmd.pop_fix = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_FINISH: begin
                o_cmd.load_out = !i_stat.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/fqs_dp.sv -----
`default_nettype none

module fqs_dp #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  fqs_pkg::t_dp_cmd                 i_cmd,
    output fqs_pkg::t_dp_stat                o_stat,
    input  wire [1:0]                        i_op,
    input  wire [VALUE_WIDTH-1:0]            i_item_value,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_found,
    output logic [VALUE_WIDTH-1:0]           o_front_value,
    output logic [VALUE_WIDTH-1:0]           o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]       o_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output logic [1:0]                       o_status
);
    import fqs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [PW-1:0]          n_rd_addr;

    logic [PW-1:0]          r_rd_ptr;
    logic [PW-1:0]          r_wr_ptr;
    logic [CW-1:0]          r_count;
    logic [PW-1:0]          r_scan_ptr;
    logic [CW-1:0]          r_scan_left;
    logic                   r_cmp_pend;
    logic                   r_out_valid;

    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_front;
    logic [VALUE_WIDTH-1:0] r_back;
    logic                   r_found;
    t_status                r_status;

    logic                   r_o_found;
    logic [VALUE_WIDTH-1:0] r_o_front;
    logic [VALUE_WIDTH-1:0] r_o_back;
    logic [CW-1:0]          r_o_count;
    logic                   r_o_empty;
    logic                   r_o_full;
    t_status                r_o_status;

    logic                   empty;
    logic                   full;
    logic                   out_busy;

    assign empty    = (r_count == '0);
    assign full     = (r_count == FULL_CNT);
    assign out_busy = r_out_valid && !i_out_ready;

    assign o_stat.op        = r_op;
    assign o_stat.is_empty  = empty;
    assign o_stat.scan_done = (r_scan_left == '0) && !r_cmp_pend;
    assign o_stat.out_busy  = out_busy;

    // pop reads the new front, a search walks from the scan pointer
    assign n_rd_addr = i_cmd.exec ? adv(r_rd_ptr) : r_scan_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_PUSH && !full) begin
            r_mem[r_wr_ptr] <= r_value;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_scan_left <= '0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_PUSH: begin
                        if (!full) begin
                            r_wr_ptr <= adv(r_wr_ptr);
                            r_count  <= r_count + CW'(1);
                        end
                    end
                    OP_POP: begin
                        if (!empty) begin
                            r_rd_ptr <= adv(r_rd_ptr);
                            r_count  <= r_count - CW'(1);
                        end
                    end
                    OP_SEARCH: begin
                        r_scan_left <= r_count;
                        r_cmp_pend  <= 1'b0;
                    end
                    OP_CLEAR: begin
                        r_rd_ptr <= '0;
                        r_wr_ptr <= '0;
                        r_count  <= '0;
                    end
                endcase
            end else if (i_cmd.scan) begin
                if (r_scan_left != '0) begin
                    r_scan_left <= r_scan_left - CW'(1);
                    r_cmp_pend  <= 1'b1;
                end else begin
                    r_cmp_pend  <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_op);
            r_value <= i_item_value;
        end
        if (i_cmd.exec) begin
            r_found <= 1'b0;
            unique case (r_op)
                OP_PUSH: begin
                    if (full) begin
                        r_status <= ST_PUSH_FULL;
                    end else begin
                        r_status <= ST_OK;
                        r_back   <= r_value;
                        if (empty) begin
                            r_front <= r_value;
                        end
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        r_status <= ST_POP_EMPTY;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                OP_SEARCH: begin
                    r_status   <= ST_OK;
                    r_scan_ptr <= r_rd_ptr;
                end
                OP_CLEAR: begin
                    r_status <= ST_OK;
                end
            endcase
        end
        if (i_cmd.pop_fix) begin
            r_front <= r_rd_data;
        end
        if (i_cmd.scan) begin
            if (r_scan_left != '0) begin
                r_scan_ptr <= adv(r_scan_ptr);
            end
            if (r_cmp_pend && r_rd_data == r_value) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_o_found  <= r_found;
            r_o_front  <= empty ? '0 : r_front;
            r_o_back   <= empty ? '0 : r_back;
            r_o_count  <= r_count;
            r_o_empty  <= empty;
            r_o_full   <= full;
            r_o_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_o_found;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_count       = r_o_count;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

// ----- hdl/fifo_queue_with_search_unit.sv -----
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_op, i_item_value
// out       output     o_out_valid / i_out_ready  o_found, o_front_value, o_back_value,
//                                                 o_count, o_is_empty, o_is_full, o_status
//
// one transaction at a time; push, clear and failed pop pass IDLE, EXEC, FINISH; pop adds POP_WAIT
// search reads the entry memory once per held entry in the SCAN state
// reset clears pointers, count, scan state and output valid; the entry memory is not cleared
// a finished result waits in the output register while the next transaction is taken;
// that transaction completes once the register is free
`default_nettype none

module fifo_queue_with_search_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire [1:0]                   i_op,
    input  wire [VALUE_WIDTH-1:0]       i_item_value,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic                        o_found,
    output logic [VALUE_WIDTH-1:0]      o_front_value,
    output logic [VALUE_WIDTH-1:0]      o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]  o_count,
    output logic                        o_is_empty,
    output logic                        o_is_full,
    output logic [1:0]                  o_status
);
    import fqs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    fqs_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_item_value  (i_item_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// ----- hdl/fqs_chk.sv -----
`default_nettype none

module fqs_chk #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire                        o_found,
    input wire [VALUE_WIDTH-1:0]      o_front_value,
    input wire [VALUE_WIDTH-1:0]      o_back_value,
    input wire [$clog2(DEPTH+1)-1:0]  o_count,
    input wire                        o_is_empty,
    input wire                        o_is_full,
    input wire [1:0]                  o_status
);
    import fqs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_count)
            && $stable(o_status) && $stable(o_front_value))
        else $error("result dropped or changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_count == '0))
            && (!o_is_empty || (o_front_value == '0 && o_back_value == '0)))
        else $error("empty mark or empty values wrong");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_full == (o_count == FULL_CNT)) && (o_count <= FULL_CNT))
        else $error("full mark or count out of range");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_PUSH_FULL || o_is_full)
            && (o_status != ST_POP_EMPTY || o_is_empty)
            && (!o_found || (o_status == ST_OK && !o_is_empty)))
        else $error("status inconsistent with queue state");

endmodule

bind fifo_queue_with_search_unit fqs_chk #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_fqs_chk (.*);

`default_nettype wire
